/* src/gbd_pkg.sv */
// Shared constants and types for the grid module byte deframer.
package gbd_pkg;

  localparam int unsigned GRID_SIZE   = 78;
  localparam int unsigned POS_W       = 7;
  localparam int unsigned FINDER_SIZE = 8;   // corner finder areas cover modules 0..7
  localparam int unsigned FINDER_FAR  = 69;  // far corner finders start above this
  localparam int unsigned BOX_LOW     = 67;  // inner box spans BOX_LOW+1 .. BOX_HIGH-1
  localparam int unsigned BOX_HIGH    = 75;
  localparam logic [7:0]  WHITE_LEVEL = 8'd255;

  typedef logic [POS_W-1:0] pos_t;

  typedef struct packed {
    pos_t column;
    pos_t row;
    logic skip;
  } grid_pos_t;

endpackage

/* src/gbd_pos_track.sv */
// Module position counter over the code grid with reserved-area detection.
module gbd_pos_track (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                advance,
  output gbd_pkg::grid_pos_t  pos
);

  gbd_pkg::pos_t column_r, column_nxt;
  gbd_pkg::pos_t row_r, row_nxt;
  logic          skip;

  localparam gbd_pkg::pos_t LastPos   = gbd_pkg::POS_W'(gbd_pkg::GRID_SIZE - 1);
  localparam gbd_pkg::pos_t FinderSz  = gbd_pkg::POS_W'(gbd_pkg::FINDER_SIZE);
  localparam gbd_pkg::pos_t FinderFar = gbd_pkg::POS_W'(gbd_pkg::FINDER_FAR);
  localparam gbd_pkg::pos_t BoxLow    = gbd_pkg::POS_W'(gbd_pkg::BOX_LOW);
  localparam gbd_pkg::pos_t BoxHigh   = gbd_pkg::POS_W'(gbd_pkg::BOX_HIGH);

  always_comb begin
    skip = ((column_r < FinderSz) && ((row_r < FinderSz) || (row_r > FinderFar))) ||
           ((column_r > FinderFar) && (row_r < FinderSz)) ||
           ((column_r > BoxLow) && (column_r < BoxHigh) &&
            (row_r > BoxLow) && (row_r < BoxHigh));
  end

  always_comb begin
    column_nxt = column_r;
    row_nxt    = row_r;
    if (advance) begin
      if (row_r == LastPos) begin
        row_nxt    = '0;
        // wrap the column at the end of the frame
        column_nxt = (column_r == LastPos) ? '0 : column_r + 1'b1;
      end else begin
        row_nxt = row_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      column_r <= '0;
      row_r    <= '0;
    end else begin
      column_r <= column_nxt;
      row_r    <= row_nxt;
    end
  end

  assign pos.column = column_r;
  assign pos.row    = row_r;
  assign pos.skip   = skip;

endmodule

/* src/grid_module_byte_deframer.sv */
// Top level: sample-to-bit deframer with LSB-first byte packing and end-of-message detection.
// Output: a completed byte is registered into out_, or into the skid entry while out_ still holds a result.
// Throughput: one input word per cycle; a two-entry output buffer keeps input open
// while one result waits, and in_stall rises only when both entries hold results.
// Reset: synchronous active-low rst_n clears position, bit count, accumulator,
// zero-byte flag, end-of-message flag and the output buffer's valid flags.
module grid_module_byte_deframer (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_module_sample,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_data_byte,
  output logic       out_last
);

  gbd_pkg::grid_pos_t pos;

  logic       accept;
  logic       active;
  logic       take_bit;
  logic       push;
  logic       pop;
  logic [7:0] byte_full;
  logic       is_last;

  logic [2:0] bit_pos_r, bit_pos_nxt;
  logic [7:0] acc_r, acc_nxt;
  logic       zero_seen_r, zero_seen_nxt;
  logic       done_r, done_nxt;

  logic       out_valid_r;
  logic [7:0] out_byte_r;
  logic       out_last_r;
  logic       skid_valid_r;
  logic [7:0] skid_byte_r;
  logic       skid_last_r;

  assign in_stall = skid_valid_r;
  assign accept   = in_valid && !in_stall;
  assign active   = accept && !done_r;
  assign take_bit = active && !pos.skip;

  gbd_pos_track u_pos (
    .clk     (clk),
    .rst_n   (rst_n),
    .advance (active),
    .pos     (pos)
  );

  always_comb begin
    byte_full     = acc_r | (8'(in_module_sample != gbd_pkg::WHITE_LEVEL) << bit_pos_r);
    is_last       = zero_seen_r && (byte_full == 8'd0);
    push          = take_bit && (bit_pos_r == 3'd7);
    bit_pos_nxt   = bit_pos_r;
    acc_nxt       = acc_r;
    zero_seen_nxt = zero_seen_r;
    done_nxt      = done_r;
    if (take_bit) begin
      bit_pos_nxt = bit_pos_r + 1'b1;
      if (push) begin
        acc_nxt       = '0;
        zero_seen_nxt = (byte_full == 8'd0);
        done_nxt      = is_last;
      end else begin
        acc_nxt = byte_full;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bit_pos_r   <= '0;
      acc_r       <= '0;
      zero_seen_r <= 1'b0;
      done_r      <= 1'b0;
    end else begin
      bit_pos_r   <= bit_pos_nxt;
      acc_r       <= acc_nxt;
      zero_seen_r <= zero_seen_nxt;
      done_r      <= done_nxt;
    end
  end

  // Two-entry output buffer: out_ register in front, skid entry behind.
  assign pop = out_valid_r && !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      if (pop) begin
        if (skid_valid_r) begin
          out_valid_r  <= 1'b1;
          skid_valid_r <= 1'b0;
        end else begin
          out_valid_r <= push;
        end
      end else if (push) begin
        if (!out_valid_r) begin
          out_valid_r <= 1'b1;
        end else begin
          skid_valid_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      if (skid_valid_r) begin
        out_byte_r <= skid_byte_r;
        out_last_r <= skid_last_r;
      end else begin
        out_byte_r <= byte_full;
        out_last_r <= is_last;
      end
    end else if (push) begin
      if (!out_valid_r) begin
        out_byte_r <= byte_full;
        out_last_r <= is_last;
      end else begin
        skid_byte_r <= byte_full;
        skid_last_r <= is_last;
      end
    end
  end

  assign out_valid     = out_valid_r;
  assign out_data_byte = out_byte_r;
  assign out_last      = out_last_r;

endmodule
